// ===== src/tmsr_pkg.sv =====
// Package for the tagged merge sort ranker: payload structs, bank control
// struct and shared constants. No dependencies.
`timescale 1ns / 1ps

package tmsr_pkg;

    localparam int SCORE_W           = 16;
    localparam int TAG_W             = 8;
    localparam int RANK_W            = 5;
    localparam int MAX_ITEMS_DEFAULT = 16;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [TAG_W-1:0]          tag;
        logic                      last;
    } in_item_t;

    typedef struct packed {
        logic signed [SCORE_W-1:0] sorted_score;
        logic [TAG_W-1:0]          sorted_tag;
        logic [RANK_W-1:0]         rank;
        logic                      end_of_run;
    } out_item_t;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [TAG_W-1:0]          tag;
    } entry_t;

    typedef struct packed {
        logic wr_en;
        logic wr_bank;
        logic rd_en;
        logic rd_bank;
    } bank_ctl_t;

endpackage

// ===== src/tmsr_bank.sv =====
// Entry bank: one write port, two read ports with registered read data.
// Depends on tmsr_pkg for the entry type.
`timescale 1ns / 1ps

module tmsr_bank #(
    parameter int DEPTH = tmsr_pkg::MAX_ITEMS_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic            clk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  tmsr_pkg::entry_t wr_data,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr_a,
    input  logic [AW-1:0]   rd_addr_b,
    output tmsr_pkg::entry_t rd_data_a,
    output tmsr_pkg::entry_t rd_data_b
);

    tmsr_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

// ===== src/tmsr_ctrl.sv =====
// Sequencer for the ranker: batch load, bottom-up merge passes between two
// banks, and emission through an output register. Depends on tmsr_pkg.
`timescale 1ns / 1ps

module tmsr_ctrl #(
    parameter int MAX_ITEMS = tmsr_pkg::MAX_ITEMS_DEFAULT,
    parameter int AW        = $clog2(MAX_ITEMS)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  tmsr_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tmsr_pkg::out_item_t  out_data,
    output tmsr_pkg::bank_ctl_t  bank_ctl,
    output logic [AW-1:0]        wr_addr,
    output tmsr_pkg::entry_t     wr_data,
    output logic [AW-1:0]        rd_addr_a,
    output logic [AW-1:0]        rd_addr_b,
    input  tmsr_pkg::entry_t     rd_data_a,
    input  tmsr_pkg::entry_t     rd_data_b
);

    localparam int CW = AW + 2;
    localparam int DW = (CW > tmsr_pkg::RANK_W) ? CW : tmsr_pkg::RANK_W;
    localparam logic [CW-1:0] MaxCount = CW'(MAX_ITEMS);
    localparam logic [CW-1:0] One      = CW'(1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MERGE,
        ST_EMIT
    } state_t;

    state_t               state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        w_reg, w_next;
    logic [CW-1:0]        a_reg, a_next;
    logic [CW-1:0]        b_reg, b_next;
    logic [CW-1:0]        a_end_reg, a_end_next;
    logic [CW-1:0]        b_end_reg, b_end_next;
    logic [CW-1:0]        k_reg, k_next;
    logic                 src_reg, src_next;
    logic [CW-1:0]        emit_pos_reg, emit_pos_next;
    logic                 q_valid_reg, q_valid_next;
    logic [CW-1:0]        q_pos_reg, q_pos_next;
    tmsr_pkg::out_item_t  out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;

    logic                 in_fire;
    logic                 has_room;
    logic [CW-1:0]        batch_n;
    logic                 a_done;
    logic                 b_done;
    logic                 take_a;
    tmsr_pkg::entry_t     pick;
    logic [CW-1:0]        a_adv;
    logic [CW-1:0]        b_adv;
    logic                 group_done;
    logic                 pass_done;
    logic [CW-1:0]        w_dbl;
    logic [CW-1:0]        lo_new;
    logic                 out_fire;
    logic                 move;
    logic                 emit_issue;
    logic [DW-1:0]        rank_full;

    function automatic logic [CW-1:0] clamp_n(input logic [CW-1:0] x,
                                              input logic [CW-1:0] n);
        clamp_n = (x < n) ? x : n;
    endfunction

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign has_room  = (count_reg < MaxCount);
    assign batch_n   = has_room ? count_reg + One : count_reg;

    assign a_done     = (a_reg >= a_end_reg);
    assign b_done     = (b_reg >= b_end_reg);
    assign take_a     = !a_done && (b_done || (rd_data_a.score <= rd_data_b.score));
    assign pick       = take_a ? rd_data_a : rd_data_b;
    assign a_adv      = a_reg + {{(CW-1){1'b0}}, take_a};
    assign b_adv      = b_reg + {{(CW-1){1'b0}}, !take_a};
    assign group_done = (a_adv >= a_end_reg) && (b_adv >= b_end_reg);
    assign pass_done  = (k_reg == count_reg - One);
    assign w_dbl      = {w_reg[CW-2:0], 1'b0};
    assign lo_new     = b_end_reg;

    assign out_fire   = out_valid_reg && out_ready;
    assign move       = q_valid_reg && (!out_valid_reg || out_fire);
    assign emit_issue = (state_reg == ST_EMIT) && (emit_pos_reg < count_reg)
                        && (!q_valid_reg || move);
    assign rank_full  = DW'(count_reg) - DW'(q_pos_reg);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        w_next         = w_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        a_end_next     = a_end_reg;
        b_end_next     = b_end_reg;
        k_next         = k_reg;
        src_next       = src_reg;
        emit_pos_next  = emit_pos_reg;
        q_valid_next   = q_valid_reg;
        q_pos_next     = q_pos_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        bank_ctl       = '0;
        wr_addr        = k_reg[AW-1:0];
        wr_data        = pick;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (has_room)
                    begin
                        bank_ctl.wr_en = 1'b1;
                        wr_addr        = count_reg[AW-1:0];
                        wr_data.score  = in_data.score;
                        wr_data.tag    = in_data.tag;
                        count_next     = count_reg + One;
                    end
                    if (in_data.last)
                    begin
                        src_next      = 1'b0;
                        w_next        = One;
                        emit_pos_next = '0;
                        q_valid_next  = 1'b0;
                        state_next    = (batch_n > One) ? ST_SETUP : ST_EMIT;
                    end
                end
            end
            ST_SETUP:
            begin
                a_next     = '0;
                b_next     = w_reg;
                a_end_next = clamp_n(w_reg, count_reg);
                b_end_next = clamp_n(w_dbl, count_reg);
                k_next     = '0;
                state_next = ST_MERGE;
            end
            ST_MERGE:
            begin
                bank_ctl.wr_en = 1'b1;
                k_next         = k_reg + One;
                if (pass_done)
                begin
                    src_next      = !src_reg;
                    w_next        = w_dbl;
                    emit_pos_next = '0;
                    q_valid_next  = 1'b0;
                    state_next    = (w_dbl < count_reg) ? ST_SETUP : ST_EMIT;
                end
                else if (group_done)
                begin
                    a_next     = lo_new;
                    b_next     = lo_new + w_reg;
                    a_end_next = clamp_n(lo_new + w_reg, count_reg);
                    b_end_next = clamp_n(lo_new + w_dbl, count_reg);
                end
                else
                begin
                    a_next = a_adv;
                    b_next = b_adv;
                end
            end
            ST_EMIT:
            begin
                if (emit_issue)
                begin
                    emit_pos_next = emit_pos_reg + One;
                    q_pos_next    = emit_pos_reg;
                    q_valid_next  = 1'b1;
                end
                else if (move)
                begin
                    q_valid_next = 1'b0;
                end
                if (move)
                begin
                    out_next.sorted_score = rd_data_a.score;
                    out_next.sorted_tag   = rd_data_a.tag;
                    out_next.rank         = rank_full[tmsr_pkg::RANK_W-1:0];
                    out_next.end_of_run   = (q_pos_reg + One == count_reg);
                    out_valid_next        = 1'b1;
                end
                else if (out_fire)
                begin
                    out_valid_next = 1'b0;
                end
                if (out_fire && out_reg.end_of_run)
                begin
                    count_next = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        bank_ctl.wr_bank = (state_reg == ST_IDLE) ? 1'b0 : !src_reg;
        bank_ctl.rd_bank = src_reg;
        bank_ctl.rd_en   = (state_reg == ST_SETUP) || (state_reg == ST_MERGE) || emit_issue;
    end

    assign rd_addr_a = (state_reg == ST_EMIT) ? emit_pos_reg[AW-1:0] : a_next[AW-1:0];
    assign rd_addr_b = b_next[AW-1:0];

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            src_reg       <= 1'b0;
            q_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            w_reg         <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            a_end_reg     <= '0;
            b_end_reg     <= '0;
            k_reg         <= '0;
            emit_pos_reg  <= '0;
            q_pos_reg     <= '0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            src_reg       <= src_next;
            q_valid_reg   <= q_valid_next;
            out_valid_reg <= out_valid_next;
            w_reg         <= w_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            a_end_reg     <= a_end_next;
            b_end_reg     <= b_end_next;
            k_reg         <= k_next;
            emit_pos_reg  <= emit_pos_next;
            q_pos_reg     <= q_pos_next;
            out_reg       <= out_next;
        end
    end

endmodule

// ===== src/tagged_merge_sort_ranker_top.sv =====
// Top level of the tagged merge sort ranker: two ping-pong entry banks and
// the sequencer, with bank port steering. Depends on tmsr_pkg, tmsr_bank, tmsr_ctrl.
//
//   channel | handshake            | payload
//   --------+----------------------+----------------------------------------
//   input   | in_valid / in_ready  | in_data  : score, tag, last
//   output  | out_valid / out_ready| out_data : sorted_score, sorted_tag,
//           |                      |            rank, end_of_run
//
// Loading takes one cycle per transaction. A last item starts ceil(log2 n)
// merge passes, each a setup step and then one entry per cycle through a bank
// with two registered read ports. Emission then issues one bank read per cycle
// while the output is not stalled; a read passes the bank read register, then
// the output register. Results leave one per cycle while out_ready is high.
// in_ready is low from the last item until the final result is taken. Reset
// clears the item count and control; bank contents stay as they are.
`timescale 1ns / 1ps

module tagged_merge_sort_ranker_top #(
    parameter int MAX_ITEMS = tmsr_pkg::MAX_ITEMS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tmsr_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output tmsr_pkg::out_item_t out_data
);

    localparam int AW = $clog2(MAX_ITEMS);

    tmsr_pkg::bank_ctl_t bank_ctl;
    logic [AW-1:0]       wr_addr;
    tmsr_pkg::entry_t    wr_data;
    logic [AW-1:0]       rd_addr_a;
    logic [AW-1:0]       rd_addr_b;
    tmsr_pkg::entry_t    rd_data_a;
    tmsr_pkg::entry_t    rd_data_b;
    tmsr_pkg::entry_t    b0_data_a, b0_data_b;
    tmsr_pkg::entry_t    b1_data_a, b1_data_b;
    logic                b0_we, b1_we, b0_re, b1_re;

    assign b0_we = bank_ctl.wr_en && !bank_ctl.wr_bank;
    assign b1_we = bank_ctl.wr_en &&  bank_ctl.wr_bank;
    assign b0_re = bank_ctl.rd_en && !bank_ctl.rd_bank;
    assign b1_re = bank_ctl.rd_en &&  bank_ctl.rd_bank;

    assign rd_data_a = bank_ctl.rd_bank ? b1_data_a : b0_data_a;
    assign rd_data_b = bank_ctl.rd_bank ? b1_data_b : b0_data_b;

    tmsr_bank #(
        .DEPTH (MAX_ITEMS),
        .AW    (AW)
    ) u_bank0 (
        .clk       (clk),
        .wr_en     (b0_we),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (b0_re),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (b0_data_a),
        .rd_data_b (b0_data_b)
    );

    tmsr_bank #(
        .DEPTH (MAX_ITEMS),
        .AW    (AW)
    ) u_bank1 (
        .clk       (clk),
        .wr_en     (b1_we),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (b1_re),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (b1_data_a),
        .rd_data_b (b1_data_b)
    );

    tmsr_ctrl #(
        .MAX_ITEMS (MAX_ITEMS),
        .AW        (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .bank_ctl  (bank_ctl),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

endmodule
